### src/nvmr_pkg.sv
// Shared types and codes for the nearest value match and remove block.
package nvmr_pkg;

  // Field widths fixed by the external interface
  localparam int unsigned ModeBits   = 2;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned DataBits   = 32;

  typedef enum logic [ModeBits-1:0] {
    MODE_INSERT = 2'd0,
    MODE_QUERY  = 2'd1,
    MODE_CLEAR  = 2'd2
  } mode_e;

  typedef enum logic [StatusBits-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_e;

  // Command item
  typedef struct packed {
    mode_e               mode;
    logic [DataBits-1:0] value;
  } item_t;

  // Result item
  typedef struct packed {
    logic [DataBits-1:0] match_value;
    status_e             status;
  } result_t;

  // Control part of the token that walks the cell chain
  typedef struct packed {
    logic valid;  // token present at this stage
    logic ins;    // insert token, otherwise nearest search
    logic pend;   // insert value not yet placed
    logic found;  // search has a candidate
  } tok_ctl_t;

endpackage

### src/nearest_value_match_remove_top.sv
// Top level: command control, occupancy count and the chain of storage cells.
//
// Bounded multiset of unsigned values with nearest-value extraction.
// Commands arrive on item_i and are taken on a rising edge with start high
// and busy low. Every command yields exactly one result on result_o, marked
// by done_o for a single cycle; the receiver cannot stall, so each result
// must be taken in the cycle it is shown.
// Insert and query send a token down the chain of CAPACITY cells, one cell
// per cycle: insert drops its value into the first free cell, query keeps
// the nearest stored value (ties to the smaller) and that cell is freed
// when the token leaves the last cell. Such a command gives its result
// once the token has left the last cell, and busy stays high until then,
// so the block takes no new command before the last one has its result.
// Clear, an unused mode, insert into a full table and query on an empty
// table finish at once: the result and the next command both come in the
// cycle after the transfer.
// Reset empties the table and drops any command in flight.
module nearest_value_match_remove_top
  import nvmr_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  item_t   item_i,
  output logic    done_o,
  output result_t result_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned VB = VALUE_BITS;
  localparam int unsigned WW = VB + DataBits;

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          done_q, done_d;
  result_t       res_q, res_d;

  logic          accept;
  logic          launch;
  logic          clear;
  logic          rem;
  logic [WW-1:0] key_wide;
  logic [WW-1:0] match_wide;

  // Chain links, index k feeds cell k
  tok_ctl_t      tok   [CAPACITY+1];
  logic [VB-1:0] key   [CAPACITY+1];
  logic [VB-1:0] bval  [CAPACITY+1];
  logic [VB-1:0] bdist [CAPACITY+1];
  logic [IW-1:0] bidx  [CAPACITY+1];

  assign accept   = start && !busy;
  assign busy     = (state_q == S_RUN);
  assign key_wide = {{VB{1'b0}}, item_i.value};

  // Token entering the first cell
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = launch;
    tok[0].ins   = (item_i.mode == MODE_INSERT);
    tok[0].pend  = 1'b1;
    key[0]       = key_wide[VB-1:0];
    bval[0]      = '0;
    bdist[0]     = '0;
    bidx[0]      = '0;
  end

  // Cell chain
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    nvmr_cell #(
      .VB       (VB),
      .IW       (IW),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_i     (tok[g]),
      .key_i     (key[g]),
      .bval_i    (bval[g]),
      .bdist_i   (bdist[g]),
      .bidx_i    (bidx[g]),
      .tok_o     (tok[g+1]),
      .key_o     (key[g+1]),
      .bval_o    (bval[g+1]),
      .bdist_o   (bdist[g+1]),
      .bidx_o    (bidx[g+1]),
      .clear_i   (clear),
      .rem_i     (rem),
      .rem_idx_i (bidx[CAPACITY])
    );
  end

  assign match_wide = {{DataBits{1'b0}}, bval[CAPACITY]};

  // Command sequencing, count and result
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    done_d  = 1'b0;
    res_d   = res_q;
    launch  = 1'b0;
    clear   = 1'b0;
    rem     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.match_value = '0;
          res_d.status      = ST_OK;
          case (item_i.mode)
            MODE_INSERT: begin
              if (count_q == CW'(CAPACITY)) begin
                res_d.status = ST_FULL;
                done_d       = 1'b1;
              end else begin
                launch  = 1'b1;
                state_d = S_RUN;
              end
            end
            MODE_QUERY: begin
              if (count_q == '0) begin
                res_d.status = ST_EMPTY;
                done_d       = 1'b1;
              end else begin
                launch  = 1'b1;
                state_d = S_RUN;
              end
            end
            MODE_CLEAR: begin
              clear   = 1'b1;
              count_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_RUN: begin
        if (tok[CAPACITY].valid) begin
          state_d           = S_IDLE;
          done_d            = 1'b1;
          res_d.match_value = '0;
          res_d.status      = ST_OK;
          if (tok[CAPACITY].ins) begin
            count_d = count_q + 1'b1;
          end else if (tok[CAPACITY].found) begin
            rem               = 1'b1;
            count_d           = count_q - 1'b1;
            res_d.match_value = match_wide[DataBits-1:0];
          end else begin
            res_d.status = ST_EMPTY;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  // Result payload, no reset
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### src/nvmr_cell.sv
// One storage cell of the chain: holds a value, places inserts, scores searches.
module nvmr_cell
  import nvmr_pkg::*;
#(
  parameter int unsigned VB       = 32,
  parameter int unsigned IW       = 6,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // token from the previous cell
  input  tok_ctl_t      tok_i,
  input  logic [VB-1:0] key_i,
  input  logic [VB-1:0] bval_i,
  input  logic [VB-1:0] bdist_i,
  input  logic [IW-1:0] bidx_i,
  // token to the next cell
  output tok_ctl_t      tok_o,
  output logic [VB-1:0] key_o,
  output logic [VB-1:0] bval_o,
  output logic [VB-1:0] bdist_o,
  output logic [IW-1:0] bidx_o,
  // broadcast commands
  input  logic          clear_i,
  input  logic          rem_i,
  input  logic [IW-1:0] rem_idx_i
);

  logic          valid_q, valid_d;
  logic [VB-1:0] value_q, value_d;
  tok_ctl_t      tok_q, tok_d;
  logic [VB-1:0] key_q, bval_q, bval_d, bdist_q, bdist_d;
  logic [IW-1:0] bidx_q, bidx_d;
  logic [VB-1:0] delta;
  logic          better;
  logic          take;

  // Distance to the key and candidate test, ties to the smaller value
  always_comb begin
    delta  = (value_q >= key_i) ? (value_q - key_i) : (key_i - value_q);
    better = valid_q && (!tok_i.found || (delta < bdist_i) ||
                         ((delta == bdist_i) && (value_q < bval_i)));
    take   = tok_i.valid && tok_i.ins && tok_i.pend && !valid_q;
  end

  // Token update
  always_comb begin
    tok_d   = tok_i;
    bval_d  = bval_i;
    bdist_d = bdist_i;
    bidx_d  = bidx_i;
    if (tok_i.valid && !tok_i.ins && better) begin
      tok_d.found = 1'b1;
      bval_d      = value_q;
      bdist_d     = delta;
      bidx_d      = IW'(CELL_IDX);
    end
    if (take) begin
      tok_d.pend = 1'b0;
    end
  end

  // Cell contents
  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    if (clear_i) begin
      valid_d = 1'b0;
    end else if (rem_i && (rem_idx_i == IW'(CELL_IDX))) begin
      valid_d = 1'b0;
    end else if (take) begin
      valid_d = 1'b1;
      value_d = key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    key_q   <= key_i;
    bval_q  <= bval_d;
    bdist_q <= bdist_d;
    bidx_q  <= bidx_d;
  end

  assign tok_o   = tok_q;
  assign key_o   = key_q;
  assign bval_o  = bval_q;
  assign bdist_o = bdist_q;
  assign bidx_o  = bidx_q;

endmodule

### verif/nearest_value_match_remove_tb.sv
// Testbench for the nearest value match and remove block: directed table, then random phases.
`timescale 1ns / 1ps

module testbench;
  import nvmr_pkg::*;

  localparam int unsigned CAPACITY      = 64;
  localparam int unsigned RANDOM_ITEMS  = 1450;
  localparam int unsigned MAX_GAP       = 19;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned DRAIN_LIMIT   = 2000;
  // Mode code the block must ignore
  localparam mode_e       MODE_SPARE    = mode_e'(2'd3);

  typedef struct packed {
    item_t   cmd;
    logic    typed;  // want holds a hand-written result
    result_t want;
  } directed_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start = 1'b0;
  logic    busy;
  item_t   cmd_item = '0;
  logic    done_o;
  result_t table_result;

  // Shadow copy of the table
  logic [DataBits-1:0] shadow_value [CAPACITY];
  bit                  shadow_used  [CAPACITY];
  int unsigned         shadow_count;

  result_t     pending_results [$];
  int unsigned fail_count;
  int unsigned results_seen;
  bit          gaps_on;

  nearest_value_match_remove_top #(
    .CAPACITY  (CAPACITY),
    .VALUE_BITS(DataBits)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (cmd_item),
    .done_o  (done_o),
    .result_o(table_result)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
  endfunction

  // Apply one command to the shadow table and return the result it should give
  function automatic result_t table_step(item_t cmd);
    result_t             res;
    bit                  placed;
    bit                  found;
    int unsigned         best;
    logic [DataBits-1:0] delta;
    logic [DataBits-1:0] best_dist;
    res.match_value = '0;
    res.status      = ST_OK;
    placed          = 1'b0;
    found           = 1'b0;
    best            = 0;
    best_dist       = '0;
    case (cmd.mode)
      MODE_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          for (int i = 0; i < CAPACITY && !placed; i++) begin
            if (!shadow_used[i]) begin
              shadow_used[i]  = 1'b1;
              shadow_value[i] = cmd.value;
              shadow_count++;
              placed = 1'b1;
            end
          end
        end
      end
      MODE_QUERY: begin
        // nearest by distance, ties to the smaller value, lowest cell first
        for (int i = 0; i < CAPACITY; i++) begin
          if (shadow_used[i]) begin
            delta = (shadow_value[i] >= cmd.value) ? shadow_value[i] - cmd.value
                                                   : cmd.value - shadow_value[i];
            if (!found || delta < best_dist ||
                (delta == best_dist && shadow_value[i] < shadow_value[best])) begin
              found     = 1'b1;
              best      = i;
              best_dist = delta;
            end
          end
        end
        if (!found) begin
          res.status = ST_EMPTY;
        end else begin
          res.match_value   = shadow_value[best];
          shadow_used[best] = 1'b0;
          shadow_count--;
        end
      end
      MODE_CLEAR: begin
        for (int i = 0; i < CAPACITY; i++) shadow_used[i] = 1'b0;
        shadow_count = 0;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic directed_row_t mk_row(mode_e m, logic [DataBits-1:0] v, bit typed,
                                           logic [DataBits-1:0] match, status_e st);
    directed_row_t row;
    row.cmd.mode          = m;
    row.cmd.value         = v;
    row.typed             = typed;
    row.want.match_value  = match;
    row.want.status       = st;
    return row;
  endfunction

  // Values biased towards duplicates, ties and the ends of the range
  function automatic logic [DataBits-1:0] pick_value();
    logic [DataBits-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5, 6:    v = $urandom_range(0, 15);
      7:          v = 32'hFFFF_FFF0 + $urandom_range(0, 15);
      8:          v = 32'h1 << $urandom_range(0, DataBits - 1);
      default:    v = 32'h7FFF_FFF0 + $urandom_range(0, 32);
    endcase
    return v;
  endfunction

  // Issue one command after an optional gap; start stays high after the transfer
  task automatic issue_cmd(item_t cmd, bit typed, result_t want);
    int unsigned gap;
    result_t     predicted;
    gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    cmd_item <= cmd;
    do @(posedge clk_i); while (busy);
    predicted = table_step(cmd);
    if (typed) predicted = want;
    pending_results = {pending_results, predicted};
  endtask

  // Hold off until every outstanding result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result %0d not expected: match %h status %0d", results_seen,
                               table_result.match_value, table_result.status));
      end else begin
        want = pending_results.pop_front();
        if (table_result.match_value !== want.match_value)
          note_failure($sformatf("result %0d match_value: expected %h, got %h", results_seen,
                                 want.match_value, table_result.match_value));
        if (table_result.status !== want.status)
          note_failure($sformatf("result %0d status: expected %0d, got %0d", results_seen,
                                 want.status, table_result.status));
      end
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    directed_row_t directed_rows [22];
    item_t         cmd;
    result_t       no_result;
    int unsigned   random_sent;
    int unsigned   phase_len;
    int unsigned   insert_pct;
    int unsigned   phase_idx;
    int unsigned   roll;
    int unsigned   wait_cycles;

    fail_count   = 0;
    results_seen = 0;
    shadow_count = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_used[i]  = 1'b0;
      shadow_value[i] = '0;
    end
    no_result   = '0;
    random_sent = 0;
    phase_idx   = 0;
    gaps_on     = 1'b1;

    directed_rows = '{
      mk_row(MODE_QUERY,  32'h0000_0000, 1, 32'h0,         ST_EMPTY),  // empty table
      mk_row(MODE_SPARE,  32'hFFFF_FFFF, 1, 32'h0,         ST_OK),     // unused mode
      mk_row(MODE_INSERT, 32'h0000_0000, 1, 32'h0,         ST_OK),
      mk_row(MODE_INSERT, 32'hFFFF_FFFF, 1, 32'h0,         ST_OK),
      mk_row(MODE_INSERT, 32'd100,       1, 32'h0,         ST_OK),
      mk_row(MODE_INSERT, 32'd100,       1, 32'h0,         ST_OK),     // duplicate
      mk_row(MODE_INSERT, 32'd200,       1, 32'h0,         ST_OK),
      mk_row(MODE_QUERY,  32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, ST_OK),
      mk_row(MODE_QUERY,  32'h0000_0000, 1, 32'h0,         ST_OK),
      mk_row(MODE_QUERY,  32'd150,       0, 32'h0,         ST_OK),     // tie, smaller wins
      mk_row(MODE_QUERY,  32'h0000_0000, 0, 32'h0,         ST_OK),     // key below minimum
      mk_row(MODE_QUERY,  32'h7FFF_FFFF, 0, 32'h0,         ST_OK),
      mk_row(MODE_QUERY,  32'd1234,      1, 32'h0,         ST_EMPTY),
      mk_row(MODE_INSERT, 32'hAAAA_AAAA, 1, 32'h0,         ST_OK),
      mk_row(MODE_INSERT, 32'h5555_5555, 1, 32'h0,         ST_OK),
      mk_row(MODE_QUERY,  32'h8000_0000, 0, 32'h0,         ST_OK),
      mk_row(MODE_CLEAR,  32'h1234_5678, 1, 32'h0,         ST_OK),
      mk_row(MODE_QUERY,  32'hFFFF_FFFF, 1, 32'h0,         ST_EMPTY),
      mk_row(MODE_INSERT, 32'd7,         1, 32'h0,         ST_OK),
      mk_row(MODE_CLEAR,  32'hFFFF_FFFF, 1, 32'h0,         ST_OK),
      mk_row(MODE_QUERY,  32'd7,         1, 32'h0,         ST_EMPTY),
      mk_row(MODE_SPARE,  32'h0000_0000, 1, 32'h0,         ST_OK)
    };

    // Reset
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (directed_rows[i])
      issue_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    // Random phases: fill-heavy, mixed and drain-heavy mixes of commands
    while (random_sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 160);
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 20;
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        cmd.value = pick_value();
        if (roll == 0) begin
          cmd.mode = MODE_CLEAR;
        end else if (roll == 1) begin
          cmd.mode = MODE_SPARE;
        end else if (roll < insert_pct) begin
          cmd.mode = MODE_INSERT;
        end else begin
          cmd.mode = MODE_QUERY;
        end
        issue_cmd(cmd, 1'b0, no_result);
        if (cmd.mode != MODE_SPARE) random_sent++;
      end
      // let the pipeline empty now and then
      if (phase_idx == 0 || $urandom_range(0, 2) == 0) drain_results();
      phase_idx++;
    end

    // Wind down
    start <= 1'b0;
    wait_cycles = 0;
    while (pending_results.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (CAPACITY + 16) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_results.size()));

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
